### hdl/dig_pkg.sv
// shared types, codes and constants of the disk image geometry and sector map
package dig_pkg;

    localparam int DRIVES     = 3;
    localparam int MAXRES     = 6;
    localparam int DIDX_W     = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int SLOTS      = 2 * DRIVES;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RES_W      = $clog2(MAXRES + 1);

    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 8;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    // command codes
    localparam logic CMD_MOUNT  = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    // image kinds
    localparam logic [2:0] IMG_NONE   = 3'd0;
    localparam logic [2:0] IMG_RAW_RW = 3'd1;
    localparam logic [2:0] IMG_RAW_RO = 3'd2;
    localparam logic [2:0] IMG_DSK_RW = 3'd3;
    localparam logic [2:0] IMG_DSK_RO = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_MOUNT = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // mount outcomes
    localparam logic [1:0] ST_HEADER = 2'd0;
    localparam logic [1:0] ST_GUESS  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // shape byte layout
    localparam logic [7:0] SHAPE_DS   = 8'h80;
    localparam logic [7:0] SHAPE_DD   = 8'h40;
    localparam logic [7:0] SHAPE_SPT  = 8'h3f;
    localparam logic [7:0] SPT_DD_BIT = 8'h10;
    localparam logic [7:0] TRK_DS_BIT = 8'h40;

    // header limits
    localparam logic [7:0] SPT_LIMIT    = 8'd32;
    localparam logic [7:0] TRACK_LIMIT  = 8'd64;
    localparam logic [7:0] SPT_DD_MIN   = 8'd16;
    localparam logic [7:0] SIDES_DOUBLE = 8'd2;
    localparam logic [7:0] DENS_DOUBLE  = 8'd2;
    localparam logic [7:0] DENS_UNKNOWN = 8'd0;
    localparam logic [7:0] SIDES_UNKNOWN = 8'd0;

    // known raw image sizes
    localparam logic [23:0] SIZE_SSSD = 24'(9 * 40 * 256);
    localparam logic [23:0] SIZE_DSSD = 24'(9 * 40 * 2 * 256);
    localparam logic [23:0] SIZE_DSDD = 24'(9 * 40 * 4 * 256);
    localparam logic [7:0]  GUESS_SPT_SD  = 8'd9;
    localparam logic [7:0]  GUESS_SPT_DD  = 8'd18;
    localparam logic [7:0]  GUESS_TRK_40  = 8'd40;
    localparam logic [7:0]  GUESS_TRK_80  = 8'd80;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_result_t;

endpackage

### hdl/dig_div.sv
// serial restoring divider, one quotient bit per cycle
module dig_div
    import dig_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_result_t           result
);

    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= DIV_CNT_W'(DIVIDEND_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

### hdl/disk_image_geometry_and_sector_map.sv
// disk image geometry table and sector map, top level with sequencer
// mount: busy through the 16-step serial divider (sector count by sectors per track) and
//   the table update, one result as busy falls; for drive >= DRIVES neither busy nor result
// access: after the plan state the slot walk goes one slot a cycle over write and read
//   slots of each drive, a result for each planned slot and none if no slot is planned
// results cannot be stalled; a new item may start during the final result transfer
// rst_n clears the geometry table, mounted and write-protect bits and the sequencer
module disk_image_geometry_and_sector_map
    import dig_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [1:0]  drive,
    input  logic [2:0]  image_kind,
    input  logic [15:0] total_sectors,
    input  logic [7:0]  header_sectors_per_track,
    input  logic [7:0]  header_tracks,
    input  logic [7:0]  header_sides,
    input  logic [7:0]  header_density,
    input  logic [23:0] image_size,
    input  logic [6:0]  request_mask,
    input  logic [7:0]  track_head,
    input  logic [7:0]  sector,
    output logic        result_strobe,
    output logic [1:0]  kind,
    output logic [1:0]  mount_status,
    output logic [1:0]  drive_out,
    output logic [7:0]  shape,
    output logic [7:0]  track_count,
    output logic [23:0] byte_offset,
    output logic        last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MOUNT,
        S_PLAN,
        S_SLOT
    } state_t;

    state_t state_reg;

    // geometry table, one entry per drive
    logic [7:0]        shape_reg   [DRIVES];
    logic [7:0]        tracks_reg  [DRIVES];
    logic [DRIVES-1:0] mounted_reg;
    logic [DRIVES-1:0] wp_reg;

    // latched item fields
    logic [1:0]  drive_reg;
    logic [2:0]  img_reg;
    logic [15:0] nsec_reg;
    logic [7:0]  spt_reg;
    logic [7:0]  htr_reg;
    logic [7:0]  sides_reg;
    logic [7:0]  dens_reg;
    logic [23:0] size_reg;
    logic [6:0]  mask_reg;
    logic [7:0]  ts_reg;
    logic [7:0]  sec_reg;

    // access sequencing
    logic [SLOTS-1:0]  pending_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [RES_W-1:0]  cnt_reg;

    // result registers
    logic        strobe_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  status_reg;
    logic [1:0]  drv_out_reg;
    logic [7:0]  shape_out_reg;
    logic [7:0]  tracks_out_reg;
    logic [23:0] offset_reg;
    logic        last_reg;

    logic        accept;
    div_result_t div_res;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // shared divider: track count from sector total, remainder for the header check
    dig_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (command == CMD_MOUNT)),
        .dividend (total_sectors),
        .divisor  (header_sectors_per_track),
        .result   (div_res)
    );

    // ---------------- mount decode ----------------
    logic [15:0] hdr_prod;
    logic [16:0] hdr_total;
    logic        img_empty;
    logic        img_dsk;
    logic        hdr_ok;
    logic [7:0]  m_sectors;
    logic [7:0]  m_tracks;
    logic [1:0]  m_status;
    logic        m_ok;
    logic [7:0]  m_shape;
    logic [7:0]  m_trk;
    logic        m_wp;
    logic [DIDX_W-1:0] m_idx;

    always_comb
    begin
        hdr_prod  = spt_reg * htr_reg;
        hdr_total = (sides_reg == SIDES_DOUBLE) ? {hdr_prod, 1'b0} : {1'b0, hdr_prod};
        img_empty = !(img_reg inside {IMG_RAW_RW, IMG_RAW_RO, IMG_DSK_RW, IMG_DSK_RO});
        img_dsk   = img_reg inside {IMG_DSK_RW, IMG_DSK_RO};
        hdr_ok    = img_dsk && (spt_reg != 8'd0) && (spt_reg < SPT_LIMIT)
                    && (htr_reg < TRACK_LIMIT) && (sides_reg <= SIDES_DOUBLE)
                    && (dens_reg <= DENS_DOUBLE) && (div_res.remainder == '0)
                    && ((htr_reg == 8'd0) || (hdr_total == {1'b0, nsec_reg}))
                    && (size_reg >= {nsec_reg, 8'h00});

        m_sectors = 8'd0;
        m_tracks  = 8'd0;
        if (img_empty)
        begin
            m_status = ST_EMPTY;
        end
        else if (hdr_ok)
        begin
            m_status  = ST_HEADER;
            m_sectors = spt_reg;
            m_tracks  = htr_reg;
            if (htr_reg == 8'd0)
            begin
                // track count implied by the sector total
                m_tracks = div_res.quotient[7:0];
                if ((sides_reg == SIDES_DOUBLE)
                    || ((sides_reg == SIDES_UNKNOWN) && (m_tracks >= TRACK_LIMIT)))
                begin
                    m_sectors = m_sectors | SHAPE_DS;
                end
            end
            else if (sides_reg == SIDES_DOUBLE)
            begin
                m_tracks  = {htr_reg[6:0], 1'b0};
                m_sectors = m_sectors | SHAPE_DS;
            end
            if ((dens_reg == DENS_DOUBLE)
                || ((dens_reg == DENS_UNKNOWN) && (spt_reg >= SPT_DD_MIN)))
            begin
                m_sectors = m_sectors | SHAPE_DD;
            end
        end
        else
        begin
            // no usable header: guess from the image size
            m_tracks = GUESS_TRK_40;
            if (size_reg == SIZE_SSSD)
            begin
                m_sectors = GUESS_SPT_SD;
            end
            else if (size_reg == SIZE_DSSD)
            begin
                m_sectors = GUESS_SPT_DD;
            end
            else if (size_reg == SIZE_DSDD)
            begin
                m_sectors = GUESS_SPT_DD;
                m_tracks  = GUESS_TRK_80;
            end
            m_status = (m_sectors != 8'd0) ? ST_GUESS : ST_REJECT;
        end

        m_ok = (m_status == ST_HEADER) || (m_status == ST_GUESS);
        if (m_ok)
        begin
            m_shape = m_sectors;
            if ((m_sectors & SPT_DD_BIT) != 8'd0)
            begin
                m_shape = m_shape | SHAPE_DD;
            end
            if ((m_tracks & TRK_DS_BIT) != 8'd0)
            begin
                m_shape = m_shape | SHAPE_DS;
            end
            m_trk = m_tracks;
        end
        else
        begin
            m_shape = 8'd0;
            m_trk   = 8'd0;
        end
        m_wp  = m_ok && (img_reg inside {IMG_RAW_RO, IMG_DSK_RO});
        m_idx = DIDX_W'(drive_reg);
    end

    // ---------------- access plan ----------------
    // bit 2d is the write slot of drive d, bit 2d+1 its read slot
    logic [SLOTS-1:0] plan;

    always_comb
    begin
        logic [7:0] p_trk;
        logic [6:0] p_wr;
        logic [6:0] p_rd;
        logic       p_fit;
        for (int d = 0; d < DRIVES; d++)
        begin
            p_trk = shape_reg[d][7] ? ts_reg : {1'b0, ts_reg[7:1]};
            p_wr  = mask_reg >> d;
            p_rd  = mask_reg >> (d + 4);
            p_fit = mounted_reg[d] && (p_trk < tracks_reg[d])
                    && (sec_reg < (shape_reg[d] & SHAPE_SPT));
            plan[2*d]     = p_wr[0] && p_fit && !wp_reg[d];
            plan[2*d + 1] = p_rd[0] && p_fit;
        end
    end

    // ---------------- slot walk ----------------
    logic [DIDX_W-1:0] s_idx;
    logic [7:0]        s_shape;
    logic [7:0]        s_trk;
    logic [13:0]       s_prod;
    logic [14:0]       s_sum;
    logic              s_emit;
    logic [SLOTS-1:0]  pending_next;
    logic              s_final;

    always_comb
    begin
        s_idx        = DIDX_W'(slot_reg >> 1);
        s_shape      = shape_reg[s_idx];
        s_trk        = s_shape[7] ? ts_reg : {1'b0, ts_reg[7:1]};
        s_prod       = s_trk * s_shape[5:0];
        s_sum        = {1'b0, s_prod} + {7'd0, sec_reg};
        s_emit       = pending_reg[slot_reg];
        pending_next = pending_reg & ~(SLOTS'(1) << slot_reg);
        // this slot ends the item if nothing is left or the result cap is hit
        s_final      = (pending_next == '0)
                       || (s_emit && (cnt_reg == RES_W'(MAXRES - 1)));
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mounted_reg <= '0;
            wp_reg      <= '0;
            pending_reg <= '0;
            slot_reg    <= '0;
            cnt_reg     <= '0;
            strobe_reg  <= 1'b0;
            for (int d = 0; d < DRIVES; d++)
            begin
                shape_reg[d]  <= 8'd0;
                tracks_reg[d] <= 8'd0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (command == CMD_ACCESS)
                        begin
                            state_reg <= S_PLAN;
                        end
                        else if ({1'b0, drive} < 3'(DRIVES))
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= S_MOUNT;
                    end
                end
                S_MOUNT:
                begin
                    shape_reg[m_idx]   <= m_shape;
                    tracks_reg[m_idx]  <= m_trk;
                    mounted_reg[m_idx] <= m_ok;
                    wp_reg[m_idx]      <= m_wp;
                    strobe_reg         <= 1'b1;
                    kind_reg           <= KIND_MOUNT;
                    status_reg         <= m_status;
                    drv_out_reg        <= drive_reg;
                    shape_out_reg      <= m_shape;
                    tracks_out_reg     <= m_trk;
                    offset_reg         <= 24'd0;
                    last_reg           <= 1'b1;
                    state_reg          <= S_IDLE;
                end
                S_PLAN:
                begin
                    pending_reg <= plan;
                    slot_reg    <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= (plan == '0) ? S_IDLE : S_SLOT;
                end
                S_SLOT:
                begin
                    pending_reg <= pending_next;
                    slot_reg    <= slot_reg + 1'b1;
                    if (s_emit)
                    begin
                        cnt_reg        <= cnt_reg + 1'b1;
                        strobe_reg     <= 1'b1;
                        kind_reg       <= slot_reg[0] ? KIND_READ : KIND_WRITE;
                        status_reg     <= ST_HEADER;
                        drv_out_reg    <= 2'(s_idx);
                        shape_out_reg  <= s_shape;
                        tracks_out_reg <= tracks_reg[s_idx];
                        offset_reg     <= {1'b0, s_sum, 8'h00};
                        last_reg       <= s_final;
                    end
                    if (s_final)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // item fields, captured on the start transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_reg <= drive;
            img_reg   <= image_kind;
            nsec_reg  <= total_sectors;
            spt_reg   <= header_sectors_per_track;
            htr_reg   <= header_tracks;
            sides_reg <= header_sides;
            dens_reg  <= header_density;
            size_reg  <= image_size;
            mask_reg  <= request_mask;
            ts_reg    <= track_head;
            sec_reg   <= sector;
        end
    end

    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign mount_status  = status_reg;
    assign drive_out     = drv_out_reg;
    assign shape         = shape_out_reg;
    assign track_count   = tracks_out_reg;
    assign byte_offset   = offset_reg;
    assign last          = last_reg;

    // ---------------- assertions ----------------
    // a mount gives exactly one result, so it is always the final one
    a_mount_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (kind == KIND_MOUNT) |-> last)
        else $error("mount result without last");

    // the next item cannot produce a result right after a final one
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |=> !result_strobe)
        else $error("result right after final result");

    // more results of this item are due, so no new item may start
    a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> busy)
        else $error("idle while results remain");

    // writes never go to a write-protected drive
    a_no_protected_write: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && (kind == KIND_WRITE) |-> !wp_reg[DIDX_W'(drive_out)])
        else $error("write result for protected drive");

endmodule
